>>> rtl/core/ppsch_pkg.sv
// Shared types, constants and helpers for the priority process scheduler.
package ppsch_pkg;

    // Table geometry and field widths
    localparam int SLOTS    = 64;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int ID_W     = 6;
    localparam int PRIO_W   = 7;
    localparam int NICE_W   = 4;
    localparam int ROUND_W  = 32;
    localparam int TIME_W   = 32;
    localparam int TICK_W   = 16;

    // Stream payload widths
    localparam int S_DATA_W = 80;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 1;

    // Niceness divider widths: slept * 10 and (ran + slept) << 3
    localparam int DIV_W    = TICK_W + 4;
    localparam int SUM_W    = TICK_W + 1;
    localparam int QUO_W    = NICE_W;

    // Scheduling constants
    localparam int DYN_MAX      = 100;
    localparam int NICE_BIAS    = 5;
    localparam int NICE_SCALE   = 10;
    localparam int NICE_DEFAULT = 5;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_PICK   = 2'd1,
        OP_DONE   = 2'd2,
        OP_SETRUN = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DIV,
        ST_FIN
    } t_state;

    // One slot of the process table
    typedef struct packed {
        logic [PRIO_W-1:0]  prio;
        logic [NICE_W-1:0]  nice;
        logic [ROUND_W-1:0] rounds;
        logic [TIME_W-1:0]  created;
    } t_entry;

    // Control from the sequencer to the scan comparator
    typedef struct packed {
        logic              clear;
        logic              valid;
        logic              run;
        logic [SLOT_W-1:0] idx;
    } t_scan_ctl;

    // Best candidate found so far
    typedef struct packed {
        logic              have;
        logic [SLOT_W-1:0] idx;
        logic [PRIO_W-1:0] dyn;
        t_entry            entry;
    } t_best;

    // Dynamic priority: static - niceness + bias, clamped to 0..DYN_MAX
    function automatic logic [PRIO_W-1:0] dyn_prio(input t_entry e);
        logic [PRIO_W:0] biased;
        logic [PRIO_W:0] diff;
        logic [PRIO_W-1:0] res;
        biased = {1'b0, e.prio} + (PRIO_W+1)'(NICE_BIAS);
        diff   = biased - (PRIO_W+1)'(e.nice);
        if (biased < (PRIO_W+1)'(e.nice)) begin
            res = '0;
        end else if (diff > (PRIO_W+1)'(DYN_MAX)) begin
            res = PRIO_W'(DYN_MAX);
        end else begin
            res = diff[PRIO_W-1:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/ppsch_slot_table.sv
// Process slot table: one write port, one registered read port.
module ppsch_slot_table
    import ppsch_pkg::*;
(
    input  logic              i_clk,
    input  logic [SLOT_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [SLOT_W-1:0] i_wr_addr,
    input  t_entry            i_wr_data,
    output t_entry            o_rd_data
);

    t_entry r_mem [SLOTS];
    t_entry r_rd_data;

    // Write the addressed slot
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/ppsch_scan_unit.sv
// Scan comparator: tracks the best runnable slot over one table sweep.
module ppsch_scan_unit
    import ppsch_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_ctl i_ctl,
    input  t_entry    i_entry,
    output t_best     o_best
);

    logic              r_have;
    logic [SLOT_W-1:0] r_idx;
    logic [PRIO_W-1:0] r_dyn;
    t_entry            r_entry;

    logic [PRIO_W-1:0] cand_dyn;
    logic              better;

    // Rank the candidate: lower dynamic priority, fewer rounds, earlier creation
    always_comb begin
        cand_dyn = dyn_prio(i_entry);
        better   = !r_have || (cand_dyn < r_dyn) ||
                   ((cand_dyn == r_dyn) &&
                    ((i_entry.rounds < r_entry.rounds) ||
                     ((i_entry.rounds == r_entry.rounds) &&
                      (i_entry.created < r_entry.created))));
    end

    // Clear at the start of a sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (i_ctl.clear) begin
            r_have <= 1'b0;
        end else if (i_ctl.valid && i_ctl.run && better) begin
            r_have <= 1'b1;
        end
    end

    // Hold the winner; ascending scan with strict compare keeps the lower slot
    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && i_ctl.valid && i_ctl.run && better) begin
            r_idx   <= i_ctl.idx;
            r_dyn   <= cand_dyn;
            r_entry <= i_entry;
        end
    end

    assign o_best.have  = r_have;
    assign o_best.idx   = r_idx;
    assign o_best.dyn   = r_dyn;
    assign o_best.entry = r_entry;

endmodule

>>> rtl/core/ppsch_nice_div.sv
// Niceness unit: slept * 10 / (ran + slept), one quotient bit per cycle.
module ppsch_nice_div
    import ppsch_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [TICK_W-1:0] i_ran,
    input  logic [TICK_W-1:0] i_slept,
    output logic              o_done,
    output logic [NICE_W-1:0] o_nice
);

    logic             r_busy;
    logic             r_done;
    logic [1:0]       r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic             r_zero;

    logic [SUM_W-1:0] total;
    logic [DIV_W-1:0] scaled;
    logic             take;

    // Form dividend and divisor; the quotient never exceeds ten, so four bits
    always_comb begin
        total  = SUM_W'(i_ran) + SUM_W'(i_slept);
        scaled = (DIV_W'(i_slept) << 3) + (DIV_W'(i_slept) << 1);
        take   = (r_rem >= r_dsh);
    end

    // Sequence the four restoring steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Subtract the shifted divisor where it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= scaled;
            r_dsh  <= DIV_W'(total) << 3;
            r_quo  <= '0;
            r_zero <= (total == '0);
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo <= {r_quo[QUO_W-2:0], take};
            r_dsh <= r_dsh >> 1;
        end
    end

    assign o_done = r_done;
    assign o_nice = r_zero ? NICE_W'(NICE_DEFAULT) : r_quo;

endmodule

>>> rtl/core/priority_process_scheduler_core.sv
// Priority process scheduler: sequencer, runnable flags and result register.
// Write slot and set runnable go straight to the result state; run done first
// waits for the four-step niceness divider; pick sweeps the table, then drains.
// A pick sweeps the slot table through its single read port, one slot a cycle.
// One item at a time: a beat is taken only when idle; a stalled output holds it off.
// Reset clears the runnable flags and control only; table entries are not cleared.
module priority_process_scheduler_core
    import ppsch_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // slot[5:0], runnable[6], static_priority[13:7], created_at[45:14],
    // ran_ticks[61:46], slept_ticks[77:62], zero fill [79:78]
    input  logic [S_DATA_W-1:0] s_tdata,
    // opcode[1:0]
    input  logic [S_USER_W-1:0] s_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    // chosen_slot[5:0], chosen_priority[12:6], new_niceness[16:13], zero fill [23:17]
    output logic [M_DATA_W-1:0] m_tdata,
    // found[0]
    output logic [M_USER_W-1:0] m_tuser
);

    t_state r_state, n_state;

    // Captured item
    t_op               r_op;
    logic [ID_W-1:0]   r_slot;
    logic              r_run;
    logic [PRIO_W-1:0] r_sprio;
    logic [TIME_W-1:0] r_ctime;

    // Sweep counter and compare stage
    logic [SLOT_W-1:0] r_idx;
    logic              r_cmp_vld;
    logic              r_cmp_run;
    logic [SLOT_W-1:0] r_cmp_idx;

    logic [SLOTS-1:0]  r_runnable;

    // Result register
    logic              r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic [M_USER_W-1:0] r_out_user;

    // Unpacked input fields
    t_op               in_op;
    logic [ID_W-1:0]   in_slot;
    logic              in_run;
    logic [PRIO_W-1:0] in_sprio;
    logic [TIME_W-1:0] in_ctime;
    logic [TICK_W-1:0] in_ran;
    logic [TICK_W-1:0] in_slept;

    logic              accept;
    logic              out_load;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_addr;

    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    t_entry            mem_wr_data;
    logic [SLOT_W-1:0] mem_rd_addr;
    t_entry            mem_rd_data;

    logic              run_wr_en;
    logic [SLOT_W-1:0] run_wr_addr;
    logic              run_wr_val;

    logic              res_found;
    logic [ID_W-1:0]   res_slot;
    logic [PRIO_W-1:0] res_prio;
    logic [NICE_W-1:0] res_nice;

    t_scan_ctl         scan_ctl;
    t_best             best;
    logic              div_start;
    logic              div_done;
    logic [NICE_W-1:0] div_nice;

    // Unpack the input beat
    always_comb begin
        in_op    = t_op'(s_tuser);
        in_slot  = s_tdata[5:0];
        in_run   = s_tdata[6];
        in_sprio = s_tdata[13:7];
        in_ctime = s_tdata[45:14];
        in_ran   = s_tdata[61:46];
        in_slept = s_tdata[77:62];
    end

    assign accept    = s_tvalid && s_tready;
    assign slot_ok   = (32'(r_slot) < 32'(SLOTS));
    assign slot_addr = SLOT_W'(r_slot);
    assign div_start = accept && (in_op == OP_DONE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_op)
                        OP_PICK:   n_state = ST_SCAN;
                        OP_DONE:   n_state = ST_DIV;
                        OP_WRITE,
                        OP_SETRUN: n_state = ST_FIN;
                    endcase
                end
            end
            ST_SCAN: begin
                if (r_idx == SLOT_W'(SLOTS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_FIN;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: handshake, table access and result
    always_comb begin
        s_tready    = (r_state == ST_IDLE);
        out_load    = (r_state == ST_FIN) && (!r_out_valid || m_tready);
        mem_rd_addr = (r_state == ST_SCAN) ? r_idx : slot_addr;
        mem_wr_en   = 1'b0;
        mem_wr_addr = slot_addr;
        mem_wr_data = mem_rd_data;
        run_wr_en   = 1'b0;
        run_wr_addr = slot_addr;
        run_wr_val  = r_run;
        res_found   = 1'b0;
        res_slot    = '0;
        res_prio    = '0;
        res_nice    = '0;
        if (r_state == ST_FIN) begin
            unique case (r_op)
                OP_WRITE: begin
                    mem_wr_en           = out_load && slot_ok;
                    run_wr_en           = out_load && slot_ok;
                    mem_wr_data.prio    = r_sprio;
                    mem_wr_data.nice    = NICE_W'(NICE_DEFAULT);
                    mem_wr_data.rounds  = '0;
                    mem_wr_data.created = r_ctime;
                end
                OP_PICK: begin
                    mem_wr_en          = out_load && best.have;
                    run_wr_en          = out_load && best.have;
                    mem_wr_addr        = best.idx;
                    run_wr_addr        = best.idx;
                    run_wr_val         = 1'b0;
                    mem_wr_data        = best.entry;
                    mem_wr_data.rounds = best.entry.rounds + ROUND_W'(1);
                    res_found          = best.have;
                    res_slot           = best.have ? ID_W'(best.idx) : '0;
                    res_prio           = best.have ? best.dyn : '0;
                end
                OP_DONE: begin
                    mem_wr_en        = out_load && slot_ok;
                    run_wr_en        = out_load && slot_ok;
                    mem_wr_data.nice = div_nice;
                    res_nice         = slot_ok ? div_nice : '0;
                end
                OP_SETRUN: begin
                    run_wr_en = out_load && slot_ok;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
        end
    end

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op    <= in_op;
            r_slot  <= in_slot;
            r_run   <= in_run;
            r_sprio <= in_sprio;
            r_ctime <= in_ctime;
        end
    end

    // Advance the sweep and feed the compare stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= '0;
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
        r_cmp_run <= r_runnable[r_idx];
        r_cmp_idx <= r_idx;
    end

    // Runnable flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_runnable <= '0;
        end else if (run_wr_en) begin
            r_runnable[run_wr_addr] <= run_wr_val;
        end
    end

    // Result register: load when free or being drained, drop on take
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {7'b0, res_nice, res_prio, res_slot};
            r_out_user <= res_found;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;
    assign m_tuser  = r_out_user;

    assign scan_ctl.clear = accept && (in_op == OP_PICK);
    assign scan_ctl.valid = r_cmp_vld;
    assign scan_ctl.run   = r_cmp_run;
    assign scan_ctl.idx   = r_cmp_idx;

    ppsch_slot_table u_table (
        .i_clk     (i_clk),
        .i_rd_addr (mem_rd_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (mem_rd_data)
    );

    ppsch_scan_unit u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_entry (mem_rd_data),
        .o_best  (best)
    );

    ppsch_nice_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_ran   (in_ran),
        .i_slept (in_slept),
        .o_done  (div_done),
        .o_nice  (div_nice)
    );

endmodule

>>> verif/tb_priority_process_scheduler_core.sv
// Self-checking testbench for the priority process scheduler core.
module tb_priority_process_scheduler_core;
    import ppsch_pkg::*;

    // One result beat as it leaves the block
    typedef struct packed {
        logic              found;
        logic [ID_W-1:0]   slot;
        logic [PRIO_W-1:0] prio;
        logic [NICE_W-1:0] nice;
    } t_sched_reply;

    // Shadow of the process table; predicts each reply and checks the block's answer
    class sched_scoreboard;
        bit                 ready_flag[SLOTS];
        logic [PRIO_W-1:0]  base_prio[SLOTS];
        logic [NICE_W-1:0]  nice_val[SLOTS];
        logic [ROUND_W-1:0] round_cnt[SLOTS];
        logic [TIME_W-1:0]  born_at[SLOTS];
        t_sched_reply       awaited_replies[$];
        int                 fail_count;

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                ready_flag[i] = 1'b0;
                base_prio[i]  = '0;
                nice_val[i]   = '0;
                round_cnt[i]  = '0;
                born_at[i]    = '0;
            end
            fail_count = 0;
        endfunction

        // Static priority minus niceness plus bias, clamped to 0..DYN_MAX
        function int effective_prio(int idx);
            int v;
            v = int'(base_prio[idx]) - int'(nice_val[idx]) + NICE_BIAS;
            if (v < 0) v = 0;
            if (v > DYN_MAX) v = DYN_MAX;
            return v;
        endfunction

        // Apply one accepted command beat and queue the reply it must produce
        function void log_command(t_op op, logic [ID_W-1:0] slot, logic run,
                                  logic [PRIO_W-1:0] sprio, logic [TIME_W-1:0] ctime,
                                  logic [TICK_W-1:0] ran, logic [TICK_W-1:0] slept);
            t_sched_reply r;
            bit have;
            int best;
            int best_p;
            int p;
            int total;
            int n;
            r = '0;
            have = 1'b0;
            best = 0;
            best_p = 0;
            if (op == OP_PICK) begin
                // Scan all slots: lowest dynamic priority, then fewer rounds,
                // then earlier creation, then lower slot
                for (int i = 0; i < SLOTS; i++) begin
                    if (ready_flag[i]) begin
                        p = effective_prio(i);
                        if (!have || p < best_p ||
                            (p == best_p && (round_cnt[i] < round_cnt[best] ||
                             (round_cnt[i] == round_cnt[best] &&
                              born_at[i] < born_at[best])))) begin
                            have = 1'b1;
                            best = i;
                            best_p = p;
                        end
                    end
                end
                if (have) begin
                    ready_flag[best] = 1'b0;
                    round_cnt[best] = round_cnt[best] + 1'b1;
                    r.found = 1'b1;
                    r.slot = ID_W'(best);
                    r.prio = PRIO_W'(best_p);
                end
            end else if (int'(slot) < SLOTS) begin
                case (op)
                    OP_WRITE: begin
                        ready_flag[slot] = run;
                        base_prio[slot]  = sprio;
                        born_at[slot]    = ctime;
                        round_cnt[slot]  = '0;
                        nice_val[slot]   = NICE_W'(NICE_DEFAULT);
                    end
                    OP_DONE: begin
                        total = int'(ran) + int'(slept);
                        n = (total == 0) ? NICE_DEFAULT : (int'(slept) * NICE_SCALE) / total;
                        nice_val[slot] = NICE_W'(n);
                        ready_flag[slot] = run;
                        r.nice = NICE_W'(n);
                    end
                    default: begin
                        ready_flag[slot] = run;
                    end
                endcase
            end
            awaited_replies.push_back(r);
        endfunction

        function void field_check(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        // Compare one reply beat against the oldest prediction
        function void check_reply(t_sched_reply got);
            t_sched_reply want;
            if (awaited_replies.size() == 0) begin
                $display("%0t: expected no reply, actual found=%0d slot=%0d prio=%0d nice=%0d",
                         $time, got.found, got.slot, got.prio, got.nice);
                fail_count++;
                return;
            end
            want = awaited_replies.pop_front();
            field_check("found", 32'(want.found), 32'(got.found));
            field_check("chosen_slot", 32'(want.slot), 32'(got.slot));
            field_check("chosen_priority", 32'(want.prio), 32'(got.prio));
            field_check("new_niceness", 32'(want.nice), 32'(got.nice));
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // slot[5:0], runnable[6], static_priority[13:7], created_at[45:14],
    // ran_ticks[61:46], slept_ticks[77:62], zero fill [79:78]
    logic [S_DATA_W-1:0] s_tdata = '0;
    // opcode[1:0]
    logic [S_USER_W-1:0] s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // chosen_slot[5:0], chosen_priority[12:6], new_niceness[16:13], zero fill [23:17]
    logic [M_DATA_W-1:0] m_tdata;
    // found[0]
    logic [M_USER_W-1:0] m_tuser;

    sched_scoreboard sb = new();
    bit slot_loaded[SLOTS];
    bit quiet = 1'b0;
    int hold_left = 0;

    priority_process_scheduler_core uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Mostly no gap, often a short one, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        else if (r < 92) return $urandom_range(1, 3);
        else return $urandom_range(8, 40);
    endfunction

    // Tick counts: zero, full scale, small and anything
    function automatic logic [TICK_W-1:0] tick_val();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        else if (r == 1) return '1;
        else if (r < 6) return TICK_W'($urandom_range(0, 20));
        else return TICK_W'($urandom_range(0, 65535));
    endfunction

    // Stall the result side at random
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) hold_left = idle_len();
        end
    end

    // Watch both handshakes
    always @(posedge i_clk) begin
        t_sched_reply got;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                sb.log_command(t_op'(s_tuser), s_tdata[5:0], s_tdata[6], s_tdata[13:7],
                               s_tdata[45:14], s_tdata[61:46], s_tdata[77:62]);
            end
            if (m_tvalid && m_tready) begin
                got.found = m_tuser[0];
                got.slot  = m_tdata[ID_W-1:0];
                got.prio  = m_tdata[ID_W+PRIO_W-1:ID_W];
                got.nice  = m_tdata[ID_W+PRIO_W+NICE_W-1:ID_W+PRIO_W];
                sb.check_reply(got);
            end
        end
    end

    // Drive one command beat after a random gap; return at its accepting edge
    task automatic send_cmd(t_op op, logic [ID_W-1:0] slot, logic run,
                            logic [PRIO_W-1:0] sprio, logic [TIME_W-1:0] ctime,
                            logic [TICK_W-1:0] ran, logic [TICK_W-1:0] slept);
        int gap;
        gap = idle_len();
        if (op == OP_WRITE) slot_loaded[slot] = 1'b1;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, slept, ran, ctime, sprio, run, slot};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    // Hold the sender until every predicted reply has arrived
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.awaited_replies.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Random command; never let a slot that was never written become runnable
    task automatic random_cmd();
        t_op op;
        logic [ID_W-1:0] slot;
        logic run;
        logic [PRIO_W-1:0] sprio;
        logic [TIME_W-1:0] ctime;
        int r;
        // Crowd a few slots so ties and reuse happen often
        if ($urandom_range(0, 9) < 7) slot = ID_W'($urandom_range(0, 7));
        else slot = ID_W'($urandom_range(0, SLOTS - 1));
        run = ($urandom_range(0, 3) != 0);
        r = $urandom_range(0, 9);
        if (r < 5) sprio = PRIO_W'($urandom_range(40, 44));
        else if (r < 9) sprio = PRIO_W'($urandom_range(0, DYN_MAX));
        else sprio = PRIO_W'($urandom_range(DYN_MAX + 1, 127));
        if ($urandom_range(0, 1) == 0) ctime = TIME_W'($urandom_range(0, 3));
        else ctime = TIME_W'($urandom());
        case ($urandom_range(0, 9))
            0, 1: op = OP_WRITE;
            2, 3, 4: op = OP_PICK;
            5, 6: op = OP_DONE;
            default: op = OP_SETRUN;
        endcase
        if (op != OP_WRITE && op != OP_PICK && !slot_loaded[slot]) run = 1'b0;
        send_cmd(op, slot, run, sprio, ctime, tick_val(), tick_val());
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pick, extremes, clamps and every tie-break
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_SETRUN, 6'd5,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_WRITE,  6'd0,  1'b1, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_WRITE,  6'd63, 1'b1, 7'd127, 32'hFFFF_FFFF, 16'd0,      16'd0);
        send_cmd(OP_WRITE,  6'd20, 1'b1, 7'd100, 32'd7,          16'd0,      16'd0);
        send_cmd(OP_WRITE,  6'd21, 1'b1, 7'd100, 32'd7,          16'd0,      16'd0);
        send_cmd(OP_WRITE,  6'd22, 1'b1, 7'd100, 32'd3,          16'd0,      16'd0);
        send_cmd(OP_WRITE,  6'd2,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_DONE,   6'd0,  1'b1, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_DONE,   6'd63, 1'b1, 7'd0,   32'd0,          16'd0,      16'hFFFF);
        send_cmd(OP_DONE,   6'd2,  1'b1, 7'd0,   32'd0,          16'd0,      16'd1);
        send_cmd(OP_DONE,   6'd1,  1'b0, 7'd0,   32'd0,          16'hFFFF,   16'd1);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_SETRUN, 6'd22, 1'b1, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_PICK,   6'd0,  1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        send_cmd(OP_DONE,   6'd20, 1'b0, 7'd0,   32'd0,          16'hFFFF,   16'hFFFF);
        send_cmd(OP_WRITE,  6'd63, 1'b0, 7'd50,  32'd0,          16'd0,      16'd0);
        send_cmd(OP_SETRUN, 6'd63, 1'b0, 7'd0,   32'd0,          16'd0,      16'd0);
        drain_wait();

        // Random: blocks of commands, one block without any idling
        for (int blk = 0; blk < 6; blk++) begin
            quiet = (blk == 2);
            repeat (200) random_cmd();
            quiet = 1'b0;
            drain_wait();
        end

        // Let any stray reply show up
        repeat (SLOTS + 16) @(posedge i_clk);
        if (sb.fail_count == 0) begin
            $display("priority_process_scheduler_core verification clean");
        end else begin
            $display("priority_process_scheduler_core verification failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #2_000_000;
        $display("priority_process_scheduler_core verification failed");
        $finish;
    end

endmodule
